@@ sv/clex_pkg.sv @@
package clex_pkg;

    localparam int KW_MAX_LEN = 8;
    localparam int CNT_W      = 16;
    localparam int KW_COUNT   = 35;
    localparam int KW_IDX_W   = $clog2(KW_MAX_LEN);

    localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

    typedef logic [6:0] tok_kind_t;

    localparam tok_kind_t K_INTEGRAL = 7'd35;
    localparam tok_kind_t K_DECIMAL  = 7'd36;
    localparam tok_kind_t K_SMEM     = 7'd37;
    localparam tok_kind_t K_MEM      = 7'd38;
    localparam tok_kind_t K_NA       = 7'd39;
    localparam tok_kind_t K_ERR      = 7'd40;
    localparam tok_kind_t K_CLIT     = 7'd41;
    localparam tok_kind_t K_SLIT     = 7'd42;
    localparam tok_kind_t K_LBRACK   = 7'd43;
    localparam tok_kind_t K_RBRACK   = 7'd44;
    localparam tok_kind_t K_LBRACE   = 7'd45;
    localparam tok_kind_t K_RBRACE   = 7'd46;
    localparam tok_kind_t K_LPAREN   = 7'd47;
    localparam tok_kind_t K_RPAREN   = 7'd48;
    localparam tok_kind_t K_NEGEQ    = 7'd49;
    localparam tok_kind_t K_NEG      = 7'd50;
    localparam tok_kind_t K_XOREQ    = 7'd51;
    localparam tok_kind_t K_XOR      = 7'd52;
    localparam tok_kind_t K_SEMI     = 7'd53;
    localparam tok_kind_t K_COLON    = 7'd54;
    localparam tok_kind_t K_HASH     = 7'd55;
    localparam tok_kind_t K_COMMA    = 7'd56;
    localparam tok_kind_t K_AT       = 7'd57;
    localparam tok_kind_t K_QUESTION = 7'd58;
    localparam tok_kind_t K_END      = 7'd59;
    localparam tok_kind_t K_EQQ      = 7'd60;
    localparam tok_kind_t K_EQ       = 7'd61;
    localparam tok_kind_t K_PEQ      = 7'd62;
    localparam tok_kind_t K_PP       = 7'd63;
    localparam tok_kind_t K_PLUS     = 7'd64;
    localparam tok_kind_t K_SEQ      = 7'd65;
    localparam tok_kind_t K_SS       = 7'd66;
    localparam tok_kind_t K_SREF     = 7'd67;
    localparam tok_kind_t K_REF      = 7'd68;
    localparam tok_kind_t K_MINUS    = 7'd69;
    localparam tok_kind_t K_DEQ      = 7'd70;
    localparam tok_kind_t K_DIV      = 7'd71;
    localparam tok_kind_t K_MEQ      = 7'd72;
    localparam tok_kind_t K_POW      = 7'd73;
    localparam tok_kind_t K_MULT     = 7'd74;
    localparam tok_kind_t K_MODEQ    = 7'd75;
    localparam tok_kind_t K_MOD      = 7'd76;
    localparam tok_kind_t K_NEQQ     = 7'd77;
    localparam tok_kind_t K_NOT      = 7'd78;
    localparam tok_kind_t K_GEQQ     = 7'd79;
    localparam tok_kind_t K_RIGHTEQ  = 7'd80;
    localparam tok_kind_t K_RSHIFT   = 7'd81;
    localparam tok_kind_t K_GREAT    = 7'd82;
    localparam tok_kind_t K_LEQQ     = 7'd83;
    localparam tok_kind_t K_LEFTEQ   = 7'd84;
    localparam tok_kind_t K_LSHIFT   = 7'd85;
    localparam tok_kind_t K_LESS     = 7'd86;
    localparam tok_kind_t K_ANDLEQ   = 7'd87;
    localparam tok_kind_t K_ANDL     = 7'd88;
    localparam tok_kind_t K_ANDEQ    = 7'd89;
    localparam tok_kind_t K_AND      = 7'd90;
    localparam tok_kind_t K_ORLEQ    = 7'd91;
    localparam tok_kind_t K_ORL      = 7'd92;
    localparam tok_kind_t K_OREQ     = 7'd93;
    localparam tok_kind_t K_OR       = 7'd94;
    localparam tok_kind_t K_COMMENT  = 7'd95;
    localparam tok_kind_t K_IDENT    = 7'd96;

    typedef enum logic [4:0] {
        M_IDLE, M_NUM, M_DOT, M_CQ1, M_CQ2, M_STR, M_SLASH, M_BLOCK, M_LINE,
        M_IDENT, M_PLUS, M_MINUS, M_ARROW, M_STAR, M_PCT, M_EQ, M_BANG, M_GT,
        M_GTGT, M_LT, M_LTLT, M_AMP, M_AMPAMP, M_BAR, M_BARBAR, M_TILDE,
        M_CARET
    } lex_mode_t;

    typedef logic [7:0] kw_buf_t [KW_MAX_LEN];

    // one result beat
    typedef struct packed {
        tok_kind_t        kind;
        logic [15:0]      length;
        logic [15:0]      line;
    } tok_t;

    // results of one step
    typedef struct packed {
        logic  first_vld;
        tok_t  first;
        logic  second_vld;
        tok_t  second;
    } step_out_t;

    // keyword text packed eight bytes, first character in the low byte
    function automatic logic [63:0] kw_text(input int idx);
        logic [63:0] t;
        t = '0;
        case (idx)
            0:  t = 64'h6669;
            1:  t = 64'h6669_6c65;
            2:  t = 64'h6573_6c65;
            3:  t = 64'h6f64;
            4:  t = 64'h65_6c69_6877;
            5:  t = 64'h6b_6165_7262;
            6:  t = 64'h72_6f66;
            7:  t = 64'h6863_7469_7773;
            8:  t = 64'h6573_6163;
            9:  t = 64'h74_6c75_6166_6564;
            10: t = 64'h6e72_7574_6572;
            11: t = 64'h7261_6863;
            12: t = 64'h74_726f_6873;
            13: t = 64'h74_6e69;
            14: t = 64'h74_616f_6c66;
            15: t = 64'h656c_6275_6f64;
            16: t = 64'h676e_6f6c;
            17: t = 64'h6469_6f76;
            18: t = 64'h676e_6972_7473;
            19: t = 64'h6d75_6e65;
            20: t = 64'h7463_7572_7473;
            21: t = 64'h74_736e_6f63;
            22: t = 64'h6465_6e67_6973;
            23: t = 64'h6465_6e67_6973_6e75;
            24: t = 64'h6369_7461_7473;
            25: t = 64'h66_6564_6570_7974;
            26: t = 64'h3855;
            27: t = 64'h36_3155;
            28: t = 64'h32_3355;
            29: t = 64'h34_3655;
            30: t = 64'h3849;
            31: t = 64'h36_3149;
            32: t = 64'h32_3349;
            33: t = 64'h34_3649;
            34: t = 64'h6c6f_6f62;
            default: t = '0;
        endcase
        return t;
    endfunction

    function automatic int kw_len(input int idx);
        int n;
        logic [63:0] t;
        t = kw_text(idx);
        n = 0;
        for (int i = 0; i < 8; i++)
        begin
            if (t[8*i +: 8] != 8'h00)
                n = i + 1;
        end
        return n;
    endfunction

endpackage

@@ sv/clex_kw_match.sv @@
module clex_kw_match (
    input  clex_pkg::kw_buf_t        buf_in,
    input  logic [clex_pkg::CNT_W-1:0] len,
    output clex_pkg::tok_kind_t      kind
);
    import clex_pkg::*;

    // compare the buffer against every keyword in parallel
    always_comb
    begin
        logic        hit;
        logic [63:0] t;
        kind = K_IDENT;
        for (int k = KW_COUNT - 1; k >= 0; k--)
        begin
            t   = kw_text(k);
            hit = (len == CNT_W'(kw_len(k)));
            for (int i = 0; i < 8; i++)
            begin
                if (i < kw_len(k) && buf_in[i] != t[8*i +: 8])
                    hit = 1'b0;
            end
            if (hit)
                kind = tok_kind_t'(k);
        end
    end

endmodule

@@ sv/clex_step.sv @@
module clex_step (
    input  logic                       in_eoi,
    input  logic [7:0]                 c,
    input  clex_pkg::lex_mode_t        mode,
    input  logic [clex_pkg::CNT_W-1:0] lex_cnt,
    input  logic [clex_pkg::CNT_W-1:0] line_cnt,
    input  logic                       dec_seen,
    input  logic                       star_seen,
    input  clex_pkg::tok_kind_t        ident_kind,
    output clex_pkg::lex_mode_t        mode_n,
    output logic [clex_pkg::CNT_W-1:0] lex_cnt_n,
    output logic [clex_pkg::CNT_W-1:0] line_cnt_n,
    output logic                       dec_n,
    output logic                       star_n,
    output logic                       wr_en,
    output logic [clex_pkg::KW_IDX_W-1:0] wr_idx,
    output clex_pkg::step_out_t        res
);
    import clex_pkg::*;

    logic is_dig, is_alp, is_sp, is_nl;

    assign is_dig = c >= 8'h30 && c <= 8'h39;
    assign is_alp = (c >= 8'h61 && c <= 8'h7a) || (c >= 8'h41 && c <= 8'h5a);
    assign is_sp  = c == 8'h20 || (c >= 8'd9 && c <= 8'd13);
    assign is_nl  = c == 8'h0a;

    function automatic logic [15:0] sat16(input logic [CNT_W-1:0] v);
        if (CNT_W > 16 && v > CNT_W'(16'hffff))
            return 16'hffff;
        return 16'(v);
    endfunction

    function automatic logic [CNT_W-1:0] inc(input logic [CNT_W-1:0] v);
        return (v == CNT_MAX) ? v : v + 1'b1;
    endfunction

    // default kind for a pending token closed by a foreign character
    function automatic tok_kind_t final_kind(input lex_mode_t m, input logic d,
                                             input tok_kind_t ik);
        tok_kind_t k;
        unique case (m)
            M_NUM:    k = d ? K_DECIMAL : K_INTEGRAL;
            M_IDENT:  k = ik;
            M_DOT:    k = K_MEM;
            M_CQ1, M_CQ2, M_STR, M_BLOCK: k = K_ERR;
            M_SLASH:  k = K_DIV;
            M_LINE:   k = K_COMMENT;
            M_PLUS:   k = K_PLUS;
            M_MINUS:  k = K_MINUS;
            M_ARROW:  k = K_REF;
            M_STAR:   k = K_MULT;
            M_PCT:    k = K_MOD;
            M_EQ:     k = K_EQ;
            M_BANG:   k = K_NOT;
            M_GT:     k = K_GREAT;
            M_GTGT:   k = K_RSHIFT;
            M_LT:     k = K_LESS;
            M_LTLT:   k = K_LSHIFT;
            M_AMP:    k = K_AND;
            M_AMPAMP: k = K_ANDL;
            M_BAR:    k = K_OR;
            M_BARBAR: k = K_ORL;
            M_TILDE:  k = K_NEG;
            M_CARET:  k = K_XOR;
            default:  k = K_NA;
        endcase
        return k;
    endfunction

    always_comb
    begin
        tok_kind_t  single;
        lex_mode_t  smode;
        logic       close;   // emit pending then restart with c
        logic       fdone;   // c extends and ends the token
        tok_kind_t  fkind;
        logic       adv;     // c extends and moves on
        lex_mode_t  amode;
        logic [CNT_W-1:0] lc, ln;

        mode_n     = mode;
        lex_cnt_n  = lex_cnt;
        line_cnt_n = line_cnt;
        dec_n      = dec_seen;
        star_n     = star_seen;
        wr_en      = 1'b0;
        wr_idx     = lex_cnt[KW_IDX_W-1:0];
        res        = '0;
        close      = 1'b0;
        fdone      = 1'b0;
        fkind      = K_NA;
        adv        = 1'b0;
        amode      = M_IDLE;
        single     = K_NA;
        smode      = M_IDLE;
        lc         = lex_cnt;
        ln         = line_cnt;

        // start-of-token decode
        if (is_dig)
            smode = M_NUM;
        else if (is_alp || c == 8'h5f)
            smode = M_IDENT;
        else
        begin
            unique case (c)
                8'h2e: smode = M_DOT;
                8'h27: smode = M_CQ1;
                8'h22: smode = M_STR;
                8'h2f: smode = M_SLASH;
                8'h2b: smode = M_PLUS;
                8'h2d: smode = M_MINUS;
                8'h2a: smode = M_STAR;
                8'h25: smode = M_PCT;
                8'h3d: smode = M_EQ;
                8'h21: smode = M_BANG;
                8'h3e: smode = M_GT;
                8'h3c: smode = M_LT;
                8'h26: smode = M_AMP;
                8'h7c: smode = M_BAR;
                8'h7e: smode = M_TILDE;
                8'h5e: smode = M_CARET;
                8'h5b: single = K_LBRACK;
                8'h5d: single = K_RBRACK;
                8'h7b: single = K_LBRACE;
                8'h7d: single = K_RBRACE;
                8'h28: single = K_LPAREN;
                8'h29: single = K_RPAREN;
                8'h3b: single = K_SEMI;
                8'h3a: single = K_COLON;
                8'h23: single = K_HASH;
                8'h2c: single = K_COMMA;
                8'h40: single = K_AT;
                8'h3f: single = K_QUESTION;
                default: single = K_NA;
            endcase
        end

        if (in_eoi)
        begin
            if (mode != M_IDLE)
            begin
                res.first_vld = 1'b1;
                res.first = '{final_kind(mode, dec_seen, ident_kind),
                              sat16(lex_cnt), sat16(line_cnt)};
                res.second_vld = 1'b1;
                res.second = '{K_END, 16'd0, sat16(line_cnt)};
            end
            else
            begin
                res.first_vld = 1'b1;
                res.first = '{K_END, 16'd0, sat16(line_cnt)};
            end
            mode_n = M_IDLE; lex_cnt_n = '0; dec_n = 1'b0; star_n = 1'b0;
        end
        else
        begin
            // per-mode continuation
            unique case (mode)
                M_IDLE: close = 1'b1;
                M_NUM:
                    if (is_dig)
                    begin
                        adv = 1'b1; amode = M_NUM;
                    end
                    else if (c == 8'h2e)
                    begin
                        if (dec_seen) begin fdone = 1'b1; fkind = K_ERR; end
                        else begin adv = 1'b1; amode = M_NUM; dec_n = 1'b1; end
                    end
                    else
                        close = 1'b1;
                M_DOT:
                    if (c == 8'h3f) begin fdone = 1'b1; fkind = K_SMEM; end
                    else if (is_dig) begin adv = 1'b1; amode = M_NUM; dec_n = 1'b1; end
                    else close = 1'b1;
                M_CQ1: begin adv = 1'b1; amode = M_CQ2; end
                M_CQ2: begin fdone = 1'b1; fkind = (c == 8'h27) ? K_CLIT : K_ERR; end
                M_STR:
                    if (c == 8'h22) begin fdone = 1'b1; fkind = K_SLIT; end
                    else begin adv = 1'b1; amode = M_STR; end
                M_SLASH:
                    if (c == 8'h3d) begin fdone = 1'b1; fkind = K_DEQ; end
                    else if (c == 8'h2a) begin adv = 1'b1; amode = M_BLOCK; star_n = 1'b0; end
                    else if (c == 8'h2f) begin adv = 1'b1; amode = M_LINE; end
                    else close = 1'b1;
                M_BLOCK:
                    if (star_seen && c == 8'h2f) begin fdone = 1'b1; fkind = K_COMMENT; end
                    else begin adv = 1'b1; amode = M_BLOCK; star_n = (c == 8'h2a); end
                M_LINE:
                    if (is_nl) close = 1'b1;
                    else begin adv = 1'b1; amode = M_LINE; end
                M_IDENT:
                    if (is_alp || is_dig || c == 8'h5f) begin adv = 1'b1; amode = M_IDENT; end
                    else close = 1'b1;
                M_PLUS:
                    if (c == 8'h3d) begin fdone = 1'b1; fkind = K_PEQ; end
                    else if (c == 8'h2b) begin fdone = 1'b1; fkind = K_PP; end
                    else close = 1'b1;
                M_MINUS:
                    if (c == 8'h3d) begin fdone = 1'b1; fkind = K_SEQ; end
                    else if (c == 8'h2d) begin fdone = 1'b1; fkind = K_SS; end
                    else if (c == 8'h3e) begin adv = 1'b1; amode = M_ARROW; end
                    else close = 1'b1;
                M_ARROW:
                    if (c == 8'h3f) begin fdone = 1'b1; fkind = K_SREF; end
                    else close = 1'b1;
                M_STAR:
                    if (c == 8'h3d) begin fdone = 1'b1; fkind = K_MEQ; end
                    else if (c == 8'h2a) begin fdone = 1'b1; fkind = K_POW; end
                    else close = 1'b1;
                M_PCT:
                    if (c == 8'h3d) begin fdone = 1'b1; fkind = K_MODEQ; end
                    else close = 1'b1;
                M_EQ:
                    if (c == 8'h3d) begin fdone = 1'b1; fkind = K_EQQ; end
                    else close = 1'b1;
                M_BANG:
                    if (c == 8'h3d) begin fdone = 1'b1; fkind = K_NEQQ; end
                    else close = 1'b1;
                M_GT:
                    if (c == 8'h3d) begin fdone = 1'b1; fkind = K_GEQQ; end
                    else if (c == 8'h3e) begin adv = 1'b1; amode = M_GTGT; end
                    else close = 1'b1;
                M_GTGT:
                    if (c == 8'h3d) begin fdone = 1'b1; fkind = K_RIGHTEQ; end
                    else close = 1'b1;
                M_LT:
                    if (c == 8'h3d) begin fdone = 1'b1; fkind = K_LEQQ; end
                    else if (c == 8'h3c) begin adv = 1'b1; amode = M_LTLT; end
                    else close = 1'b1;
                M_LTLT:
                    if (c == 8'h3d) begin fdone = 1'b1; fkind = K_LEFTEQ; end
                    else close = 1'b1;
                M_AMP:
                    if (c == 8'h26) begin adv = 1'b1; amode = M_AMPAMP; end
                    else if (c == 8'h3d) begin fdone = 1'b1; fkind = K_ANDEQ; end
                    else close = 1'b1;
                M_AMPAMP:
                    if (c == 8'h3d) begin fdone = 1'b1; fkind = K_ANDLEQ; end
                    else close = 1'b1;
                M_BAR:
                    if (c == 8'h7c) begin adv = 1'b1; amode = M_BARBAR; end
                    else if (c == 8'h3d) begin fdone = 1'b1; fkind = K_OREQ; end
                    else close = 1'b1;
                M_BARBAR:
                    if (c == 8'h3d) begin fdone = 1'b1; fkind = K_ORLEQ; end
                    else close = 1'b1;
                M_TILDE:
                    if (c == 8'h3d) begin fdone = 1'b1; fkind = K_NEGEQ; end
                    else close = 1'b1;
                M_CARET:
                    if (c == 8'h3d) begin fdone = 1'b1; fkind = K_XOREQ; end
                    else close = 1'b1;
                default: close = 1'b1;
            endcase

            if (adv || fdone)
            begin
                // take c into the pending token
                wr_en = lex_cnt < CNT_W'(KW_MAX_LEN);
                lc    = inc(lex_cnt);
                if (is_nl) ln = inc(line_cnt);
                if (fdone)
                begin
                    res.first_vld = 1'b1;
                    res.first = '{fkind, sat16(lc), sat16(ln)};
                    mode_n = M_IDLE; lex_cnt_n = '0; dec_n = 1'b0; star_n = 1'b0;
                end
                else
                begin
                    mode_n = amode; lex_cnt_n = lc;
                end
                line_cnt_n = ln;
            end
            else if (close)
            begin
                // number followed by a letter is malformed
                if (mode != M_IDLE)
                begin
                    res.first_vld = 1'b1;
                    res.first = '{(mode == M_NUM && is_alp) ? K_NA
                                  : final_kind(mode, dec_seen, ident_kind),
                                  sat16(lex_cnt), sat16(line_cnt)};
                end
                dec_n = 1'b0; star_n = 1'b0; lex_cnt_n = '0; mode_n = M_IDLE;
                if (is_sp)
                begin
                    if (is_nl) line_cnt_n = inc(line_cnt);
                end
                else
                begin
                    wr_en  = 1'b1;
                    wr_idx = '0;
                    ln     = is_nl ? inc(line_cnt) : line_cnt;
                    line_cnt_n = ln;
                    if (smode != M_IDLE)
                    begin
                        mode_n    = smode;
                        lex_cnt_n = CNT_W'(1);
                    end
                    else if (res.first_vld)
                    begin
                        res.second_vld = 1'b1;
                        res.second = '{single, 16'd1, sat16(ln)};
                    end
                    else
                    begin
                        res.first_vld = 1'b1;
                        res.first = '{single, 16'd1, sat16(ln)};
                    end
                end
            end
        end
    end

endmodule

@@ sv/c_like_token_classifier_top.sv @@
// Streaming lexer for a C-like language.
// Input channel (s_axis_*): one beat per source byte; tuser = 1 marks end of
//   input, tdata carries the byte and is ignored on end of input.
// Output channel (m_axis_*): one beat per token. tdata holds kind, length
//   and line; tlast is high on the final token caused by one input beat.
// Each input beat is decoded combinationally against the lexer state and the
//   eight-byte keyword buffer; results land in a two-entry output queue.
// The first token of a beat is offered on the cycle after acceptance.
// Throughput: one byte per cycle while the receiver is ready and at most one
//   token per beat appears; a beat that closes two tokens (a terminator that
//   is itself a token, or end of input after a pending token) holds off the
//   next beat while the single output port drains the queue.
// Reset: the lexer returns to idle with zero line and length counts and the
//   output queue empties; the keyword buffer keeps its contents.
// When the receiver stalls, tokens wait in the queue; s_axis_tready drops
//   only when the queue cannot hold what the next beat may produce.
module c_like_token_classifier_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] char_code
    input  logic        s_axis_tuser,   // [0] kind
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,   // [6:0] token_kind, [22:7] token_length,
                                        // [38:23] token_line, [39] zero pad
    output logic        m_axis_tlast    // last
);
    import clex_pkg::*;

    lex_mode_t        mode_reg, mode_next;
    logic [CNT_W-1:0] lex_cnt_reg, lex_cnt_next;
    logic [CNT_W-1:0] line_cnt_reg, line_cnt_next;
    logic             dec_reg, dec_next;
    logic             star_reg, star_next;
    logic [7:0]       kw_buf_reg [KW_MAX_LEN];

    logic             wr_en;
    logic [KW_IDX_W-1:0] wr_idx;
    tok_kind_t        ident_kind;
    step_out_t        res;
    logic             in_beat;

    // output queue: two slots
    tok_t             q_tok_reg  [2];
    logic             q_last_reg [2];
    logic [1:0]       q_cnt_reg;

    assign in_beat = s_axis_tvalid && s_axis_tready;

    clex_kw_match u_kw (
        .buf_in (kw_buf_reg),
        .len    (lex_cnt_reg),
        .kind   (ident_kind)
    );

    clex_step u_step (
        .in_eoi     (s_axis_tuser),
        .c          (s_axis_tdata),
        .mode       (mode_reg),
        .lex_cnt    (lex_cnt_reg),
        .line_cnt   (line_cnt_reg),
        .dec_seen   (dec_reg),
        .star_seen  (star_reg),
        .ident_kind (ident_kind),
        .mode_n     (mode_next),
        .lex_cnt_n  (lex_cnt_next),
        .line_cnt_n (line_cnt_next),
        .dec_n      (dec_next),
        .star_n     (star_next),
        .wr_en      (wr_en),
        .wr_idx     (wr_idx),
        .res        (res)
    );

    // advance lexer state on each accepted beat
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg     <= M_IDLE;
            lex_cnt_reg  <= '0;
            line_cnt_reg <= '0;
            dec_reg      <= 1'b0;
            star_reg     <= 1'b0;
        end
        else if (in_beat)
        begin
            mode_reg     <= mode_next;
            lex_cnt_reg  <= lex_cnt_next;
            line_cnt_reg <= line_cnt_next;
            dec_reg      <= dec_next;
            star_reg     <= star_next;
        end
    end

    // keyword buffer write
    always_ff @(posedge clk)
    begin
        if (in_beat && wr_en)
            kw_buf_reg[wr_idx] <= s_axis_tdata;
    end

    // accept only with room for two results after this cycle's drain
    logic pop;
    assign pop           = m_axis_tvalid && m_axis_tready;
    assign s_axis_tready = (q_cnt_reg == 2'd0) || (q_cnt_reg == 2'd1 && pop);

    assign m_axis_tvalid = q_cnt_reg != 2'd0;
    assign m_axis_tdata  = {1'b0, q_tok_reg[0].line, q_tok_reg[0].length, q_tok_reg[0].kind};
    assign m_axis_tlast  = q_last_reg[0];

    // queue: shift out on pop, append new results
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            q_cnt_reg <= '0;
        else
            q_cnt_reg <= q_cnt_reg - {1'b0, pop}
                         + (in_beat ? 2'(res.first_vld) + 2'(res.second_vld) : 2'd0);
    end

    always_ff @(posedge clk)
    begin
        if (pop && q_cnt_reg == 2'd2)
        begin
            q_tok_reg[0]  <= q_tok_reg[1];
            q_last_reg[0] <= q_last_reg[1];
        end
        if (in_beat && res.first_vld)
        begin
            q_tok_reg[0]  <= res.first;
            q_last_reg[0] <= !res.second_vld;
            q_tok_reg[1]  <= res.second;
            q_last_reg[1] <= 1'b1;
        end
    end

endmodule

@@ sv/clex_checker.sv @@
module clex_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        s_axis_tuser,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [39:0] m_axis_tdata,
    input logic        m_axis_tlast
);
    import clex_pkg::*;

    // end of input always yields a beat next cycle
    a_eoi_out: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready && s_axis_tuser |=> m_axis_tvalid)
        else $error("no token after end of input");

    // END tokens have zero length and close the beat
    a_end_tok: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tdata[6:0] == K_END |->
        m_axis_tdata[22:7] == 16'd0 && m_axis_tlast)
        else $error("malformed END token");

    // stalled output holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("output changed under stall");

    // a non-last beat is followed by its partner
    a_pair: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tready && !m_axis_tlast |=> m_axis_tvalid)
        else $error("second token missing");

endmodule

bind c_like_token_classifier_top clex_checker u_clex_checker (.*);

@@ bench/tb.sv @@
`timescale 1ns / 1ps

module tb;
    import clex_pkg::*;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata;
    logic        s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [39:0] m_axis_tdata;
    logic        m_axis_tlast;

    localparam int LEN_MAX = 65535;

    typedef struct packed {
        tok_kind_t   kind;
        logic [15:0] length;
        logic [15:0] line;
        logic        last;
    } token_t;

    // one directed row: beat plus optional typed-in first token
    typedef struct {
        logic       eoi;
        logic [7:0] ch;
        logic       has_exp;
        tok_kind_t  exp_kind;
        int         exp_len;
    } row_t;

    token_t     token_q[$];
    int         errors;
    int         beats_left;
    logic       stall_long;

    // lexer state held by the predictor
    lex_mode_t  mode;
    logic [7:0] kwbuf [KW_MAX_LEN];
    int         lex_len;
    int         line_no;
    logic       dec_seen;
    logic       star_seen;
    token_t     step_toks[$];

    c_like_token_classifier_top dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    function automatic bit is_dig(logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic bit is_let(logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
    endfunction

    function automatic void bump_line();
        if (line_no < LEN_MAX) line_no++;
    endfunction

    function automatic void take(logic [7:0] c);
        if (lex_len < KW_MAX_LEN) kwbuf[lex_len] = c;
        if (lex_len < LEN_MAX) lex_len++;
        if (c == 8'h0a) bump_line();
    endfunction

    function automatic void emit(tok_kind_t k);
        token_t t;
        t.kind = k;
        t.length = lex_len[15:0];
        t.line = line_no[15:0];
        t.last = 1'b0;
        step_toks.push_back(t);
        lex_len = 0;
        mode = M_IDLE;
        dec_seen = 1'b0;
        star_seen = 1'b0;
    endfunction

    // keyword lookup on the buffered identifier
    function automatic tok_kind_t word_kind();
        logic [63:0] w;
        if (lex_len > KW_MAX_LEN) return K_IDENT;
        w = '0;
        for (int i = 0; i < KW_MAX_LEN; i++)
            if (i < lex_len) w[8*i +: 8] = kwbuf[i];
        for (int k = 0; k < KW_COUNT; k++)
        begin
            if (kw_len(k) == lex_len && kw_text(k) == w) return tok_kind_t'(k);
        end
        return K_IDENT;
    endfunction

    function automatic tok_kind_t pending_kind();
        case (mode)
            M_NUM:    return dec_seen ? K_DECIMAL : K_INTEGRAL;
            M_IDENT:  return word_kind();
            M_DOT:    return K_MEM;
            M_CQ1, M_CQ2, M_STR, M_BLOCK: return K_ERR;
            M_SLASH:  return K_DIV;
            M_LINE:   return K_COMMENT;
            M_PLUS:   return K_PLUS;
            M_MINUS:  return K_MINUS;
            M_ARROW:  return K_REF;
            M_STAR:   return K_MULT;
            M_PCT:    return K_MOD;
            M_EQ:     return K_EQ;
            M_BANG:   return K_NOT;
            M_GT:     return K_GREAT;
            M_GTGT:   return K_RSHIFT;
            M_LT:     return K_LESS;
            M_LTLT:   return K_LSHIFT;
            M_AMP:    return K_AND;
            M_AMPAMP: return K_ANDL;
            M_BAR:    return K_OR;
            M_BARBAR: return K_ORL;
            M_TILDE:  return K_NEG;
            M_CARET:  return K_XOR;
            default:  return K_NA;
        endcase
    endfunction

    // open a token from idle
    function automatic void open_tok(logic [7:0] c);
        lex_mode_t m;
        tok_kind_t one;
        if (c == " " || (c >= 8'd9 && c <= 8'd13))
        begin
            if (c == 8'h0a) bump_line();
            return;
        end
        m = M_IDLE;
        one = K_NA;
        if (is_dig(c)) m = M_NUM;
        else if (is_let(c) || c == "_") m = M_IDENT;
        else
            case (c)
                ".":  m = M_DOT;
                "'":  m = M_CQ1;
                "\"": m = M_STR;
                "/":  m = M_SLASH;
                "+":  m = M_PLUS;
                "-":  m = M_MINUS;
                "*":  m = M_STAR;
                "%":  m = M_PCT;
                "=":  m = M_EQ;
                "!":  m = M_BANG;
                ">":  m = M_GT;
                "<":  m = M_LT;
                "&":  m = M_AMP;
                "|":  m = M_BAR;
                "~":  m = M_TILDE;
                "^":  m = M_CARET;
                "[":  one = K_LBRACK;
                "]":  one = K_RBRACK;
                "{":  one = K_LBRACE;
                "}":  one = K_RBRACE;
                "(":  one = K_LPAREN;
                ")":  one = K_RPAREN;
                ";":  one = K_SEMI;
                ":":  one = K_COLON;
                "#":  one = K_HASH;
                ",":  one = K_COMMA;
                "@":  one = K_AT;
                "?":  one = K_QUESTION;
                default: one = K_NA;
            endcase
        take(c);
        if (m != M_IDLE) mode = m;
        else emit(one);
    endfunction

    function automatic void close_then(logic [7:0] c);
        emit(pending_kind());
        open_tok(c);
    endfunction

    // second character of an operator: finish, extend, or close
    function automatic bit op_step(logic [7:0] c, logic [7:0] ch, tok_kind_t k);
        if (c != ch) return 1'b0;
        take(c);
        emit(k);
        return 1'b1;
    endfunction

    function automatic bit op_grow(logic [7:0] c, logic [7:0] ch, lex_mode_t m);
        if (c != ch) return 1'b0;
        take(c);
        mode = m;
        return 1'b1;
    endfunction

    function automatic void lex_char(logic [7:0] c);
        bit done;
        done = 1'b0;
        case (mode)
            M_IDLE: begin open_tok(c); return; end
            M_NUM:
            begin
                if (is_dig(c)) take(c);
                else if (c == ".")
                begin
                    take(c);
                    if (dec_seen) emit(K_ERR);
                    else dec_seen = 1'b1;
                end
                else if (is_let(c))
                begin
                    emit(K_NA);
                    open_tok(c);
                end
                else close_then(c);
                return;
            end
            M_DOT:
            begin
                if (op_step(c, "?", K_SMEM)) return;
                if (is_dig(c))
                begin
                    take(c);
                    dec_seen = 1'b1;
                    mode = M_NUM;
                    return;
                end
                close_then(c);
                return;
            end
            M_CQ1: begin take(c); mode = M_CQ2; return; end
            M_CQ2: begin take(c); emit(c == "'" ? K_CLIT : K_ERR); return; end
            M_STR: begin take(c); if (c == "\"") emit(K_SLIT); return; end
            M_SLASH:
            begin
                if (op_step(c, "=", K_DEQ)) return;
                if (op_grow(c, "*", M_BLOCK)) begin star_seen = 1'b0; return; end
                if (op_grow(c, "/", M_LINE)) return;
                close_then(c);
                return;
            end
            M_BLOCK:
            begin
                take(c);
                if (star_seen && c == "/") emit(K_COMMENT);
                else star_seen = (c == "*");
                return;
            end
            M_LINE:
            begin
                if (c == 8'h0a)
                begin
                    emit(K_COMMENT);
                    bump_line();
                end
                else take(c);
                return;
            end
            M_IDENT:
            begin
                if (is_let(c) || is_dig(c) || c == "_") take(c);
                else close_then(c);
                return;
            end
            M_PLUS:   done = op_step(c, "=", K_PEQ) || op_step(c, "+", K_PP);
            M_MINUS:  done = op_step(c, "=", K_SEQ) || op_step(c, "-", K_SS)
                             || op_grow(c, ">", M_ARROW);
            M_ARROW:  done = op_step(c, "?", K_SREF);
            M_STAR:   done = op_step(c, "=", K_MEQ) || op_step(c, "*", K_POW);
            M_PCT:    done = op_step(c, "=", K_MODEQ);
            M_EQ:     done = op_step(c, "=", K_EQQ);
            M_BANG:   done = op_step(c, "=", K_NEQQ);
            M_GT:     done = op_step(c, "=", K_GEQQ) || op_grow(c, ">", M_GTGT);
            M_GTGT:   done = op_step(c, "=", K_RIGHTEQ);
            M_LT:     done = op_step(c, "=", K_LEQQ) || op_grow(c, "<", M_LTLT);
            M_LTLT:   done = op_step(c, "=", K_LEFTEQ);
            M_AMP:    done = op_grow(c, "&", M_AMPAMP) || op_step(c, "=", K_ANDEQ);
            M_AMPAMP: done = op_step(c, "=", K_ANDLEQ);
            M_BAR:    done = op_grow(c, "|", M_BARBAR) || op_step(c, "=", K_OREQ);
            M_BARBAR: done = op_step(c, "=", K_ORLEQ);
            M_TILDE:  done = op_step(c, "=", K_NEGEQ);
            M_CARET:  done = op_step(c, "=", K_XOREQ);
            default:  begin mode = M_IDLE; open_tok(c); return; end
        endcase
        if (!done) close_then(c);
    endfunction

    // predict the tokens of one accepted beat and queue them
    function automatic int lex_beat(logic eoi, logic [7:0] c);
        int n;
        step_toks.delete();
        if (eoi)
        begin
            if (mode != M_IDLE) emit(pending_kind());
            lex_len = 0;
            emit(K_END);
        end
        else lex_char(c);
        n = step_toks.size();
        if (n > 0) step_toks[n-1].last = 1'b1;
        foreach (step_toks[i]) token_q.push_back(step_toks[i]);
        return n;
    endfunction

    // directed rows
    row_t rows[$];

    function automatic void add_row(logic e, logic [7:0] c, logic h = 0,
                                    tok_kind_t k = K_NA, int l = 0);
        row_t r;
        r.eoi = e; r.ch = c; r.has_exp = h; r.exp_kind = k; r.exp_len = l;
        rows.push_back(r);
    endfunction

    function automatic void add_text(string s);
        for (int i = 0; i < s.len(); i++) add_row(1'b0, s[i]);
    endfunction

    // random source text: mostly well-formed fragments
    string frags[] = '{"if", "elif", "else", "do", "while", "break", "for", "switch",
        "case", "default", "return", "char", "short", "int", "float", "double",
        "long", "void", "string", "enum", "struct", "const", "signed", "unsigned",
        "static", "typedef", "U8", "U16", "U32", "U64", "I8", "I16", "I32", "I64",
        "bool", "foo_1", "typedefs", "_x", "unsignedx", "42", "3.14", "1.2.3", ".5",
        ".", ".?", "7a", "'a'", "'ab", "\"hi there\"", "/* c ** x */", "// note\n",
        "+", "+=", "++", "-", "-=", "--", "->", "->?", "*", "*=", "**", "%", "%=",
        "=", "==", "!", "!=", ">", ">=", ">>", ">>=", "<", "<=", "<<", "<<=", "&",
        "&&", "&=", "&&=", "|", "||", "|=", "||=", "~", "~=", "^", "^=", "[", "]",
        "{", "}", "(", ")", ";", ":", "#", ",", "@", "?", "/", "/=", " ", "\n",
        "\t", "$", "\\"};

    // stimulus feed
    logic       feed_eoi [$];
    logic [7:0] feed_ch  [$];

    initial
    begin
        int n;
        string s;
        logic [7:0] junk;
        errors = 0;
        mode = M_IDLE;
        lex_len = 0;
        line_no = 0;
        dec_seen = 1'b0;
        star_seen = 1'b0;
        for (int i = 0; i < KW_MAX_LEN; i++) kwbuf[i] = '0;
        rst_n = 1'b0;

        // end of input straight after reset, then extremes and special cases
        add_row(1'b1, 8'h00, 1, K_END, 0);
        add_row(1'b0, 8'hff, 1, K_NA, 1);
        add_row(1'b0, 8'h00, 1, K_NA, 1);
        add_row(1'b0, 8'h80, 1, K_NA, 1);
        add_row(1'b0, "@", 1, K_AT, 1);
        add_text("9x ");
        add_text("1.2.");
        add_text("'a'");
        add_text("'ab");
        add_text("/**/");
        add_text("//z\n");
        add_text("<<=");
        add_text("\"s");
        add_row(1'b1, 8'h7f);
        foreach (rows[i])
        begin
            feed_eoi.push_back(rows[i].eoi);
            feed_ch.push_back(rows[i].ch);
        end

        // random part: fragments, noise, end-of-input marks
        n = feed_eoi.size();
        while (feed_eoi.size() < n + 1850)
        begin
            if ($urandom_range(99) < 80)
            begin
                s = frags[$urandom_range(frags.size() - 1)];
                for (int i = 0; i < s.len(); i++)
                begin
                    feed_eoi.push_back(1'b0);
                    feed_ch.push_back(s[i]);
                end
                if ($urandom_range(3) == 0)
                begin
                    feed_eoi.push_back(1'b0);
                    feed_ch.push_back(" ");
                end
            end
            else
            begin
                junk = 8'($urandom_range(255));
                feed_eoi.push_back($urandom_range(4) == 0);
                feed_ch.push_back(junk);
            end
        end
        feed_eoi.push_back(1'b1);
        feed_ch.push_back(8'h00);
        beats_left = feed_eoi.size();

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
    end

    // sender: offer beats with random gaps, none in the middle stretch
    initial
    begin
        int idx;
        int pred_n;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = 1'b0;
        idx = 0;
        @(posedge rst_n);
        while (idx < feed_eoi.size())
        begin
            @(posedge clk);
            if (s_axis_tvalid && s_axis_tready)
            begin
                pred_n = lex_beat(s_axis_tuser, s_axis_tdata);
                if (idx - 1 < rows.size() && rows[idx-1].has_exp)
                begin
                    if (pred_n == 0 || token_q[token_q.size()-pred_n].kind
                            != rows[idx-1].exp_kind
                        || token_q[token_q.size()-pred_n].length != rows[idx-1].exp_len)
                    begin
                        $display("%0t table row %0d: predictor kind %0d, typed %0d",
                                 $time, idx - 1, token_q[token_q.size()-pred_n].kind,
                                 rows[idx-1].exp_kind);
                        errors++;
                    end
                end
                beats_left--;
            end
            if (!s_axis_tvalid || s_axis_tready)
            begin
                if ((idx > 600 && idx < 900) || $urandom_range(99) >= 17)
                begin
                    s_axis_tvalid <= 1'b1;
                    s_axis_tuser  <= feed_eoi[idx];
                    s_axis_tdata  <= feed_eoi[idx] ? 8'($urandom_range(255)) : feed_ch[idx];
                    idx++;
                end
                else s_axis_tvalid <= 1'b0;
            end
        end
        // take the last beat
        @(posedge clk);
        while (!(s_axis_tvalid && s_axis_tready)) @(posedge clk);
        void'(lex_beat(s_axis_tuser, s_axis_tdata));
        beats_left--;
        s_axis_tvalid <= 1'b0;
    end

    // long hold-off of the receiver so the input backs up
    initial
    begin
        stall_long = 1'b0;
        @(posedge rst_n);
        repeat (300) @(posedge clk);
        stall_long <= 1'b1;
        repeat (80) @(posedge clk);
        stall_long <= 1'b0;
    end

    // receiver: random ready and token check
    always @(posedge clk or negedge rst_n)
    begin
        token_t got;
        token_t want;
        if (!rst_n)
            m_axis_tready <= 1'b0;
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                got.kind   = m_axis_tdata[6:0];
                got.length = m_axis_tdata[22:7];
                got.line   = m_axis_tdata[38:23];
                got.last   = m_axis_tlast;
                if (token_q.size() == 0)
                begin
                    $display("%0t unexpected token: actual %h", $time, got);
                    errors++;
                end
                else
                begin
                    want = token_q.pop_front();
                    if (got.kind != want.kind)
                    begin
                        $display("%0t kind: expected %0d actual %0d", $time, want.kind,
                                 got.kind);
                        errors++;
                    end
                    if (got.length != want.length)
                    begin
                        $display("%0t length: expected %0d actual %0d", $time,
                                 want.length, got.length);
                        errors++;
                    end
                    if (got.line != want.line)
                    begin
                        $display("%0t line: expected %0d actual %0d", $time, want.line,
                                 got.line);
                        errors++;
                    end
                    if (got.last != want.last)
                    begin
                        $display("%0t last: expected %0b actual %0b", $time, want.last,
                                 got.last);
                        errors++;
                    end
                end
            end
            // no idling between 1000 ns and 1400 ns
            m_axis_tready <= !stall_long && (($time >= 1000 && $time <= 1400)
                                             || $urandom_range(99) >= 17);
        end
    end

    // end of run
    initial
    begin
        @(posedge rst_n);
        @(posedge clk);
        while (beats_left > 0 || token_q.size() > 0) @(posedge clk);
        repeat (20) @(posedge clk);
        if (errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    initial
    begin
        #200000;
        $display("status: fail");
        $finish;
    end

endmodule

@@ files.f @@
sv/clex_pkg.sv
sv/clex_kw_match.sv
sv/clex_step.sv
sv/c_like_token_classifier_top.sv
sv/clex_checker.sv
bench/tb.sv
